// ===== rtl/hgce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgce_pkg
// Shared types and constants for the hilbert geo cell encoder.
// ----------------------------------------------------------------------------
package hgce_pkg;

	localparam int unsigned MAX_LEVEL = 31;
	localparam int unsigned LVL_W     = 5;
	localparam int unsigned ID_W      = 31;
	localparam int unsigned COORD_W   = 32;
	localparam int unsigned CELL_W    = MAX_LEVEL;
	localparam int unsigned CODE_W    = 2 * MAX_LEVEL;

	localparam logic [LVL_W-1:0] LEVEL_RESET = 5'd20;

	// half spans in 1e-7 degree units
	localparam logic signed [COORD_W-1:0] LAT_HALF = 32'sd900000000;
	localparam logic signed [COORD_W-1:0] LON_HALF = 32'sd1800000000;

	// full spans, used as divisors
	localparam logic [COORD_W-1:0] LAT_SPAN = 32'd1800000000;
	localparam logic [COORD_W-1:0] LON_SPAN = 32'd3600000000;

	// floor(2^62 / LAT_SPAN) == floor(2^63 / LON_SPAN)
	localparam logic [COORD_W-1:0] RECIP = 32'd2562047788;

	typedef struct packed {
		logic             vld;
		logic             ok;
		logic [LVL_W-1:0] lvl;
		logic [ID_W-1:0]  id;
	} hgce_ctl_t;

endpackage

// ===== rtl/hilbert_geo_cell_encoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_geo_cell_encoder_unit
// Quantizes latitude and longitude onto a 2^L grid and emits the 2L-bit
// Hilbert index of the cell pair, with validity check and id passthrough.
// ----------------------------------------------------------------------------
// One transaction per cycle in and out while the output is not stalled. The
// pipeline is the input register, the quantizer (a 32x32 reciprocal multiply
// chained with a span back-multiply, a correction step and a level shift)
// and the Hilbert transform, which handles four of its thirty bit levels per
// stage before the gray decode and interleave in the output register. The
// output register is the last stage; while it holds a result under stall the
// whole pipeline holds, and in_stall follows. grid_level is captured with each
// transaction on entry, a level of zero acting as one; change it only while
// the pipeline is empty.
module hilbert_geo_cell_encoder_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [hgce_pkg::LVL_W-1:0]          cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [hgce_pkg::ID_W-1:0]           record_id,
	input  logic signed [hgce_pkg::COORD_W-1:0] latitude,
	input  logic signed [hgce_pkg::COORD_W-1:0] longitude,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                accepted,
	output logic [hgce_pkg::ID_W-1:0]           record_id_out,
	output logic [hgce_pkg::CODE_W-1:0]         hilbert_code,
	output logic [hgce_pkg::CELL_W-1:0]         lat_cell,
	output logic [hgce_pkg::CELL_W-1:0]         lon_cell
);
	import hgce_pkg::*;

	logic [LVL_W-1:0]   grid_level_q;
	logic               en;
	logic               in_ok;
	logic [COORD_W-1:0] lat_shift, lon_shift;

	hgce_ctl_t          ctl_s1;
	logic [COORD_W-1:0] lat_shift_s1, lon_shift_s1;

	hgce_ctl_t          cell_ctl, out_ctl;
	logic [CELL_W-1:0]  q_lat_cell, q_lon_cell;

	assign en       = !(out_ctl.vld && out_stall);
	assign in_stall = out_ctl.vld && out_stall;

	assign in_ok = record_id != '0 && latitude != '0 && longitude != '0 &&
		latitude <= LAT_HALF && latitude >= -LAT_HALF &&
		longitude <= LON_HALF && longitude >= -LON_HALF;

	// offset into [0, span]; longitude may exceed the signed range
	assign lat_shift = $unsigned(latitude) + $unsigned(LAT_HALF);
	assign lon_shift = $unsigned(longitude) + $unsigned(LON_HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_level_q <= LEVEL_RESET;
		end else if (cfg_wr_en) begin
			grid_level_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.vld <= in_valid;
			ctl_s1.ok  <= in_ok;
			ctl_s1.lvl <= (grid_level_q == '0) ? LVL_W'(1) : grid_level_q;
			ctl_s1.id  <= record_id;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat_shift_s1 <= lat_shift;
			lon_shift_s1 <= lon_shift;
		end
	end

	hgce_quant u_quant (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl       (ctl_s1),
		.lat_shift (lat_shift_s1),
		.lon_shift (lon_shift_s1),
		.cell_ctl  (cell_ctl),
		.lat_cell  (q_lat_cell),
		.lon_cell  (q_lon_cell)
	);

	hgce_hilbert u_hilbert (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.cell_ctl     (cell_ctl),
		.lat_cell     (q_lat_cell),
		.lon_cell     (q_lon_cell),
		.out_ctl      (out_ctl),
		.code         (hilbert_code),
		.out_lat_cell (lat_cell),
		.out_lon_cell (lon_cell)
	);

	assign out_valid     = out_ctl.vld;
	assign accepted      = out_ctl.ok;
	assign record_id_out = out_ctl.id;

	a_reject_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> hilbert_code == '0 && lat_cell == '0 && lon_cell == '0)
		else $error("rejected transaction carries nonzero result");

	a_accept_needs_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> record_id_out != '0)
		else $error("accepted transaction with zero record id");

endmodule

// ===== rtl/hgce_quant.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgce_quant
// Grid quantizer for both axes: offset coordinate times 2^31 over the span by
// reciprocal multiply, one correction step, then scaled down to the level.
// ----------------------------------------------------------------------------
module hgce_quant (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  hgce_pkg::hgce_ctl_t             ctl,
	input  logic [hgce_pkg::COORD_W-1:0]    lat_shift,
	input  logic [hgce_pkg::COORD_W-1:0]    lon_shift,
	output hgce_pkg::hgce_ctl_t             cell_ctl,
	output logic [hgce_pkg::CELL_W-1:0]     lat_cell,
	output logic [hgce_pkg::CELL_W-1:0]     lon_cell
);
	import hgce_pkg::*;

	localparam int unsigned LANES = 2;

	function automatic logic [COORD_W-1:0] lane_span(input int ln);
		return (ln == 0) ? LAT_SPAN : LON_SPAN;
	endfunction

	// quotient estimate: lat keeps prod >> 31, lon keeps prod >> 32
	function automatic logic [COORD_W-1:0] lane_quot(input int ln, input logic [63:0] prod);
		return (ln == 0) ? prod[62:31] : prod[63:32];
	endfunction

	logic [COORD_W-1:0] shift_in [LANES];

	hgce_ctl_t          ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [COORD_W-1:0] s_s2     [LANES];
	logic [63:0]        prod_s2  [LANES];
	logic [COORD_W-1:0] s_s3     [LANES];
	logic [COORD_W-1:0] qest_s3  [LANES];
	logic [63:0]        back_s3  [LANES];
	logic [COORD_W-1:0] quo_s4   [LANES];
	logic [CELL_W-1:0]  cell_s5  [LANES];

	logic [COORD_W-1:0] qest     [LANES];
	logic [63:0]        rem      [LANES];
	logic [COORD_W-1:0] quo      [LANES];
	logic [CELL_W-1:0]  grid_pos [LANES];
	logic [CELL_W-1:0]  cell_max;

	assign shift_in[0] = lat_shift;
	assign shift_in[1] = lon_shift;

	assign cell_max = CELL_W'((32'(1) << ctl_s4.lvl) - 32'(1));

	always_comb begin
		for (int ln = 0; ln < LANES; ln++) begin
			qest[ln] = lane_quot(ln, prod_s2[ln]);
			// estimate is low by at most one
			rem[ln]  = {1'b0, s_s3[ln], 31'd0} - back_s3[ln];
			quo[ln]  = qest_s3[ln] + COORD_W'(rem[ln] >= {32'd0, lane_span(ln)});
			// top bit set only for a coordinate on the upper edge: clamp
			grid_pos[ln] = quo_s4[ln][COORD_W-1] ? cell_max :
				CELL_W'(quo_s4[ln][CELL_W-1:0] >> (LVL_W'(MAX_LEVEL) - ctl_s4.lvl));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ln = 0; ln < LANES; ln++) begin
				s_s2[ln]    <= shift_in[ln];
				prod_s2[ln] <= 64'(shift_in[ln]) * 64'(RECIP);
				s_s3[ln]    <= s_s2[ln];
				qest_s3[ln] <= qest[ln];
				back_s3[ln] <= 64'(qest[ln]) * 64'(lane_span(ln));
				quo_s4[ln]  <= quo[ln];
				cell_s5[ln] <= grid_pos[ln];
			end
		end
	end

	assign cell_ctl = ctl_s5;
	assign lat_cell = cell_s5[0];
	assign lon_cell = cell_s5[1];

	a_lat_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.vld && ctl_s3.ok |-> rem[0] < {31'd0, LAT_SPAN, 1'b0})
		else $error("latitude remainder outside one correction step");

	a_lon_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.vld && ctl_s3.ok |-> rem[1] < {31'd0, LON_SPAN, 1'b0})
		else $error("longitude remainder outside one correction step");

	a_cell_fits_level: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s5.vld && ctl_s5.ok |->
			(cell_s5[0] >> ctl_s5.lvl) == '0 && (cell_s5[1] >> ctl_s5.lvl) == '0)
		else $error("grid cell wider than grid level");

endmodule

// ===== rtl/hgce_hilbert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgce_hilbert
// Two-axis Hilbert transform, four bit levels per stage, then gray decode and
// bit interleave into the output register.
// ----------------------------------------------------------------------------
module hgce_hilbert (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  hgce_pkg::hgce_ctl_t             cell_ctl,
	input  logic [hgce_pkg::CELL_W-1:0]     lat_cell,
	input  logic [hgce_pkg::CELL_W-1:0]     lon_cell,
	output hgce_pkg::hgce_ctl_t             out_ctl,
	output logic [hgce_pkg::CODE_W-1:0]     code,
	output logic [hgce_pkg::CELL_W-1:0]     out_lat_cell,
	output logic [hgce_pkg::CELL_W-1:0]     out_lon_cell
);
	import hgce_pkg::*;

	localparam int unsigned TOP_BIT    = MAX_LEVEL - 1;
	localparam int unsigned ITERS      = 4;
	localparam int unsigned HIL_STAGES = (TOP_BIT + ITERS - 1) / ITERS;

	// bit levels TOP_BIT-g*ITERS downward; level zero and levels at or above lvl are skipped
	function automatic logic [2*CELL_W-1:0] hil_stage(
		input logic [CELL_W-1:0] a_in,
		input logic [CELL_W-1:0] b_in,
		input logic [LVL_W-1:0]  lvl,
		input int                g
	);
		logic [CELL_W-1:0] a, b, p, t;
		int                j;
		a = a_in;
		b = b_in;
		for (int m = 0; m < ITERS; m++) begin
			j = int'(TOP_BIT) - g * int'(ITERS) - m;
			if (j >= 1 && LVL_W'(j) < lvl) begin
				p = (CELL_W'(1) << j) - CELL_W'(1);
				if (a[j])
					a = a ^ p;
				if (b[j]) begin
					a = a ^ p;
				end else begin
					t = (a ^ b) & p;
					a = a ^ t;
					b = b ^ t;
				end
			end
		end
		return {a, b};
	endfunction

	hgce_ctl_t         src_ctl [HIL_STAGES];
	logic [CELL_W-1:0] src0    [HIL_STAGES];
	logic [CELL_W-1:0] src1    [HIL_STAGES];
	logic [2*CELL_W-1:0] nxt   [HIL_STAGES];

	hgce_ctl_t         ctl_s   [HIL_STAGES];
	logic [CELL_W-1:0] x0_s    [HIL_STAGES];
	logic [CELL_W-1:0] x1_s    [HIL_STAGES];
	logic [CELL_W-1:0] lc_s    [HIL_STAGES];
	logic [CELL_W-1:0] oc_s    [HIL_STAGES];

	hgce_ctl_t         ctl_s14;
	logic [CODE_W-1:0] code_s14;
	logic [CELL_W-1:0] lat_cell_s14, lon_cell_s14;

	logic [CELL_W-1:0] g0, g1, tmask;
	logic [CODE_W-1:0] ilv;

	for (genvar g = 0; g < HIL_STAGES; g++) begin : g_stage
		if (g == 0) begin : g_first
			assign src_ctl[g] = cell_ctl;
			assign src0[g]    = lat_cell;
			assign src1[g]    = lon_cell;
		end else begin : g_next
			assign src_ctl[g] = ctl_s[g-1];
			assign src0[g]    = x0_s[g-1];
			assign src1[g]    = x1_s[g-1];
		end
		assign nxt[g] = hil_stage(src0[g], src1[g], src_ctl[g].lvl, g);
	end

	// gray decode: each bit takes the parity of all higher bits of the second axis
	always_comb begin
		g1 = x1_s[HIL_STAGES-1] ^ x0_s[HIL_STAGES-1];
		for (int b = 0; b < CELL_W; b++)
			tmask[b] = ^(g1 >> (b + 1));
		g0 = x0_s[HIL_STAGES-1] ^ tmask;
		g1 = g1 ^ tmask;
		for (int k = 0; k < CELL_W; k++) begin
			ilv[2*k+1] = g0[k];
			ilv[2*k]   = g1[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < HIL_STAGES; g++)
				ctl_s[g] <= '0;
			ctl_s14 <= '0;
		end else if (en) begin
			for (int g = 0; g < HIL_STAGES; g++)
				ctl_s[g] <= src_ctl[g];
			ctl_s14 <= ctl_s[HIL_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < HIL_STAGES; g++) begin
				x0_s[g] <= nxt[g][2*CELL_W-1:CELL_W];
				x1_s[g] <= nxt[g][CELL_W-1:0];
			end
			lc_s[0] <= lat_cell;
			oc_s[0] <= lon_cell;
			for (int g = 1; g < HIL_STAGES; g++) begin
				lc_s[g] <= lc_s[g-1];
				oc_s[g] <= oc_s[g-1];
			end
			// rejected transactions leave with all result fields cleared
			code_s14     <= ctl_s[HIL_STAGES-1].ok ? ilv : '0;
			lat_cell_s14 <= ctl_s[HIL_STAGES-1].ok ? lc_s[HIL_STAGES-1] : '0;
			lon_cell_s14 <= ctl_s[HIL_STAGES-1].ok ? oc_s[HIL_STAGES-1] : '0;
		end
	end

	assign out_ctl      = ctl_s14;
	assign code         = code_s14;
	assign out_lat_cell = lat_cell_s14;
	assign out_lon_cell = lon_cell_s14;

	a_code_fits_level: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s14.vld && ctl_s14.ok |-> (code_s14 >> {ctl_s14.lvl, 1'b0}) == '0)
		else $error("hilbert code wider than twice the grid level");

	a_stage_bits_fit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[0].vld && ctl_s[0].ok |->
			(x0_s[0] >> ctl_s[0].lvl) == '0 && (x1_s[0] >> ctl_s[0].lvl) == '0)
		else $error("transform spilled above the grid level");

endmodule

// ===== test/hgce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgce_checker
// Watches the config, input and output channels of the hilbert geo cell
// encoder, predicts the cell pair and Hilbert index of every accepted fix and
// compares each delivered result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module hgce_checker
	import hgce_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [LVL_W-1:0]           cfg_wr_data,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [ID_W-1:0]            record_id,
	input  logic signed [COORD_W-1:0]  latitude,
	input  logic signed [COORD_W-1:0]  longitude,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       accepted,
	input  logic [ID_W-1:0]            record_id_out,
	input  logic [CODE_W-1:0]          hilbert_code,
	input  logic [CELL_W-1:0]          lat_cell,
	input  logic [CELL_W-1:0]          lon_cell,
	output int                         fail_count,
	output int                         pending
);

	localparam longint LAT_HALF_E7 = 64'sd900000000;
	localparam longint LON_HALF_E7 = 64'sd1800000000;

	typedef struct packed {
		logic              ok;
		logic [ID_W-1:0]   id;
		logic [CODE_W-1:0] code;
		logic [CELL_W-1:0] lat_c;
		logic [CELL_W-1:0] lon_c;
	} geo_cell_t;

	geo_cell_t        cell_q[$];
	logic [LVL_W-1:0] level_reg;
	int               errs = 0;

	initial begin
		level_reg = LEVEL_RESET;
	end

	function automatic logic [63:0] grid_cell(longint coord, longint half, int lvl);
		logic [63:0] offset;
		logic [63:0] limit;
		logic [63:0] pos;
		offset = 64'(coord + half);
		limit  = 64'd1 << lvl;
		pos    = (offset << lvl) / 64'(2 * half);
		if (pos >= limit) begin
			pos = limit - 64'd1;
		end
		return pos;
	endfunction

	// axes to transpose, then gray decode and interleave, lat bit first
	function automatic logic [CODE_W-1:0] hilbert_index(logic [63:0] lat_c,
			logic [63:0] lon_c, int lvl);
		logic [63:0]       ax [2];
		logic [63:0]       q;
		logic [63:0]       p;
		logic [63:0]       t;
		logic [CODE_W-1:0] code;
		ax[0] = lat_c;
		ax[1] = lon_c;
		for (int b = lvl - 1; b >= 1; b--) begin
			q = 64'd1 << b;
			p = q - 64'd1;
			for (int i = 0; i < 2; i++) begin
				if ((ax[i] & q) != 0) begin
					ax[0] ^= p;
				end else begin
					t = (ax[0] ^ ax[i]) & p;
					ax[0] ^= t;
					ax[i] ^= t;
				end
			end
		end
		ax[1] ^= ax[0];
		t = '0;
		for (int b = lvl - 1; b >= 1; b--) begin
			if (ax[1][b]) begin
				t ^= (64'd1 << b) - 64'd1;
			end
		end
		ax[0] ^= t;
		ax[1] ^= t;
		code = '0;
		for (int k = lvl - 1; k >= 0; k--) begin
			code = {code[CODE_W-3:0], ax[0][k], ax[1][k]};
		end
		return code;
	endfunction

	function automatic geo_cell_t encode_fix(logic [ID_W-1:0] id,
			logic signed [COORD_W-1:0] lat, logic signed [COORD_W-1:0] lon,
			logic [LVL_W-1:0] lvl_reg);
		geo_cell_t   r;
		longint      la;
		longint      lo;
		int          lvl;
		logic [63:0] lc;
		logic [63:0] oc;
		la  = lat;
		lo  = lon;
		lvl = (lvl_reg == '0) ? 1 : int'(lvl_reg);
		r   = '0;
		r.id = id;
		r.ok = id != '0 && la != 0 && lo != 0 &&
			la <= LAT_HALF_E7 && la >= -LAT_HALF_E7 &&
			lo <= LON_HALF_E7 && lo >= -LON_HALF_E7;
		if (r.ok) begin
			lc      = grid_cell(la, LAT_HALF_E7, lvl);
			oc      = grid_cell(lo, LON_HALF_E7, lvl);
			r.code  = hilbert_index(lc, oc, lvl);
			r.lat_c = lc[CELL_W-1:0];
			r.lon_c = oc[CELL_W-1:0];
		end
		return r;
	endfunction

	task automatic compare(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errs++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		geo_cell_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (cell_q.size() == 0) begin
					errs++;
					$display("%0t: unexpected transaction, expected none, actual id 0x%0h",
						$time, record_id_out);
				end else begin
					want = cell_q.pop_front();
					compare("accepted", 64'(want.ok), 64'(accepted));
					compare("record_id_out", 64'(want.id), 64'(record_id_out));
					compare("hilbert_code", 64'(want.code), 64'(hilbert_code));
					compare("lat_cell", 64'(want.lat_c), 64'(lat_cell));
					compare("lon_cell", 64'(want.lon_c), 64'(lon_cell));
				end
			end
			// level is latched on entry, so the input sees the old value
			if (in_valid && !in_stall) begin
				cell_q = {cell_q, encode_fix(record_id, latitude, longitude, level_reg)};
			end
			if (cfg_wr_en) begin
				level_reg = cfg_wr_data;
			end
		end
		pending    <= cell_q.size();
		fail_count <= errs;
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random geo fixes through the hilbert geo cell encoder
// over several grid levels, with random gaps and back-pressure, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
	import hgce_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int PHASE_FIXES  = 100;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [LVL_W-1:0]          cfg_wr_data;
	logic                      in_valid;
	logic                      in_stall;
	logic [ID_W-1:0]           record_id;
	logic signed [COORD_W-1:0] latitude;
	logic signed [COORD_W-1:0] longitude;
	logic                      out_valid;
	logic                      out_stall;
	logic                      accepted;
	logic [ID_W-1:0]           record_id_out;
	logic [CODE_W-1:0]         hilbert_code;
	logic [CELL_W-1:0]         lat_cell;
	logic [CELL_W-1:0]         lon_cell;

	int fail_count;
	int pending;
	int idle_cycles = 0;
	bit steady      = 1'b0;

	hilbert_geo_cell_encoder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.record_id     (record_id),
		.latitude      (latitude),
		.longitude     (longitude),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.record_id_out (record_id_out),
		.hilbert_code  (hilbert_code),
		.lat_cell      (lat_cell),
		.lon_cell      (lon_cell)
	);

	hgce_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.record_id     (record_id),
		.latitude      (latitude),
		.longitude     (longitude),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.record_id_out (record_id_out),
		.hilbert_code  (hilbert_code),
		.lat_cell      (lat_cell),
		.lon_cell      (lon_cell),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly none or short, now and then a long one
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge clk);
		forever begin
			n = gap_length();
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(20, 150)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_fix(input logic [ID_W-1:0] id, input logic [COORD_W-1:0] lat,
			input logic [COORD_W-1:0] lon);
		int n;
		in_valid  <= 1'b1;
		record_id <= id;
		latitude  <= lat;
		longitude <= lon;
		do @(posedge clk); while (in_stall);
		n = steady ? 0 : gap_length();
		if (n != 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_level(input logic [LVL_W-1:0] lvl);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= lvl;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic send_corners();
		send_fix(31'h7FFFFFFF, 32'sd900000000, 32'sd1800000000);
		send_fix(31'd1, -32'sd900000000, -32'sd1800000000);
		send_fix(31'd2, 32'sd1, -32'sd1);
		send_fix(31'd3, -32'sd1, 32'sd1);
		send_fix(31'd4, 32'sd450000000, -32'sd900000000);
	endtask

	function automatic logic [COORD_W-1:0] coord_in_range(longint half);
		longint c;
		case ($urandom_range(0, 5))
			0: c = longint'($urandom_range(0, 2000)) - 1000;
			1: c = half - longint'($urandom_range(0, 1000));
			2: c = longint'($urandom_range(0, 1000)) - half;
			default: c = longint'($urandom_range(0, 32'(2 * half))) - half;
		endcase
		return c[COORD_W-1:0];
	endfunction

	task automatic send_random_fix();
		logic [ID_W-1:0]    id;
		logic [COORD_W-1:0] lat;
		logic [COORD_W-1:0] lon;
		int                 r;
		id  = ID_W'($urandom);
		lat = coord_in_range(64'sd900000000);
		lon = coord_in_range(64'sd1800000000);
		r   = $urandom_range(0, 99);
		if (r < 4) begin
			id = '0;
		end else if (r < 8) begin
			lat = '0;
		end else if (r < 12) begin
			lon = '0;
		end else if (r < 16) begin
			lat = ($urandom_range(0, 1) != 0) ? 32'sd900000001 : -32'sd900000001;
		end else if (r < 20) begin
			lon = ($urandom_range(0, 1) != 0) ? 32'sd1800000001 : -32'sd1800000001;
		end else if (r < 28) begin
			lat = $urandom;
			lon = $urandom;
		end
		send_fix(id, lat, lon);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			send_random_fix();
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		record_id   = '0;
		latitude    = '0;
		longitude   = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset level, extremes and every reject reason
		send_corners();
		send_fix(31'h7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
		send_fix(31'h2AAAAAAA, 32'sh80000000, 32'sh7FFFFFFF);
		send_fix('0, 32'sd1000, 32'sd1000);
		send_fix(31'd5, '0, 32'sd1000);
		send_fix(31'd6, 32'sd1000, '0);
		send_fix(31'd7, 32'sd900000001, 32'sd1000);
		send_fix(31'd8, -32'sd900000001, 32'sd1000);
		send_fix(31'd9, 32'sd1000, 32'sd1800000001);
		send_fix(31'd10, 32'sd1000, -32'sd1800000001);
		send_fix(31'h55555555, 32'sd899999999, -32'sd1799999999);
		drain();

		set_level(5'd31);
		send_corners();
		run_random(PHASE_FIXES);
		drain();

		set_level(5'd1);
		send_corners();
		run_random(PHASE_FIXES);
		drain();

		// zero acts as the smallest level
		set_level(5'd0);
		run_random(PHASE_FIXES);
		drain();

		set_level(5'd30);
		run_random(PHASE_FIXES);
		drain();

		repeat (4) begin
			set_level(LVL_W'($urandom_range(0, 31)));
			run_random(PHASE_FIXES);
			drain();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== hilbert_geo_cell_encoder_unit.f =====
rtl/hgce_pkg.sv
rtl/hgce_quant.sv
rtl/hgce_hilbert.sv
rtl/hilbert_geo_cell_encoder_unit.sv
test/hgce_checker.sv
test/tb_top.sv
